@@ hdl/a7s_pkg.sv @@
// a7s_pkg: shared types, constants and the segment table for the
// converter-reading seven-segment scan block. No dependencies.

package a7s_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int POS_BITS    = $clog2(NUM_DIGITS);
    localparam int SAMPLE_BITS = 10;
    localparam int SCALE_BITS  = 16;
    localparam int SCALE_SHIFT = 10;
    localparam int VALUE_BITS  = 14;
    localparam int COUNT_BITS  = 4;
    localparam int SEG_BITS    = 7;
    localparam int CFG_BITS    = SCALE_BITS;

    localparam logic [VALUE_BITS-1:0] MAX_SHOWN     = 14'd9999;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = 4'd15;
    localparam logic [COUNT_BITS-1:0] REFRESH_RESET = 4'd9;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET   = 16'd50000;

    typedef enum logic [0:0] {
        REG_REFRESH_SCANS = 1'b0,
        REG_SCALE         = 1'b1
    } reg_index_t;

    typedef enum logic [0:0] {
        ACT_TICK   = 1'b0,
        ACT_SAMPLE = 1'b1
    } action_t;

    typedef struct packed {
        logic                   action;
        logic [SAMPLE_BITS-1:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic [SEG_BITS-1:0]   segments;
        logic [NUM_DIGITS-1:0] digit_enable;
        logic                  sample_taken;
    } out_beat_t;

    // segments a..g at bit0..bit6
    localparam logic [SEG_BITS-1:0] SEG_TABLE [10] = '{
        7'd63, 7'd6, 7'd91, 7'd79, 7'd102, 7'd109, 7'd125, 7'd7, 7'd127, 7'd111
    };

    function automatic logic [SEG_BITS-1:0] seg_of(input logic [3:0] d);
        logic [SEG_BITS-1:0] s;
        s = '0;
        if (d < 4'd10) begin
            s = SEG_TABLE[d];
        end
        return s;
    endfunction

endpackage

@@ hdl/a7s_scale.sv @@
// a7s_scale: scales a converter reading to hundredths and clamps to 9999.
// Depends on a7s_pkg.

module a7s_scale import a7s_pkg::*; (
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SCALE_BITS-1:0]  scale,
    output logic [VALUE_BITS-1:0]  value
);

    localparam int PROD_BITS = SAMPLE_BITS + SCALE_BITS;
    localparam int SHR_BITS  = PROD_BITS - SCALE_SHIFT;

    logic [PROD_BITS-1:0] product;
    logic [SHR_BITS-1:0]  shifted;

    assign product = PROD_BITS'(sample) * PROD_BITS'(scale);
    assign shifted = product[PROD_BITS-1:SCALE_SHIFT];
    assign value   = (shifted > SHR_BITS'(MAX_SHOWN)) ? MAX_SHOWN
                                                      : shifted[VALUE_BITS-1:0];

endmodule

@@ hdl/a7s_digit.sv @@
// a7s_digit: picks one decimal digit of the shown value and decodes it to
// segments plus a one-hot digit enable. Depends on a7s_pkg.

module a7s_digit import a7s_pkg::*; (
    input  logic [VALUE_BITS-1:0] value,
    input  logic [POS_BITS-1:0]   pos,
    output logic [SEG_BITS-1:0]   segments,
    output logic [NUM_DIGITS-1:0] digit_enable
);

    // reciprocal multiplies, exact for value below 10000
    localparam logic [11:0] RCP10   = 12'd3277;  // 2^15 / 10
    localparam logic [12:0] RCP100  = 13'd5243;  // 2^19 / 100
    localparam logic [13:0] RCP1000 = 14'd8389;  // 2^23 / 1000

    logic [25:0] p10;
    logic [26:0] p100;
    logic [27:0] p1000;
    logic [9:0]  q10;
    logic [6:0]  q100;
    logic [3:0]  q1000;
    logic [3:0]  d_tens, d_units, d_tenths, d_hundredths;
    logic [3:0]  digit;

    assign p10   = 26'(value) * 26'(RCP10);
    assign p100  = 27'(value) * 27'(RCP100);
    assign p1000 = 28'(value) * 28'(RCP1000);

    assign q10   = p10[24:15];
    assign q100  = p100[25:19];
    assign q1000 = p1000[26:23];

    assign d_tens       = q1000;
    assign d_units      = 4'(7'(q100) - 7'(q1000) * 7'd10);
    assign d_tenths     = 4'(10'(q10) - 10'(q100) * 10'd10);
    assign d_hundredths = 4'(value - 14'(q10) * 14'd10);

    always_comb begin
        case (pos)
            2'd0:    digit = d_tens;
            2'd1:    digit = d_units;
            2'd2:    digit = d_tenths;
            default: digit = d_hundredths;
        endcase
    end

    assign segments     = seg_of(digit);
    assign digit_enable = NUM_DIGITS'(1) << pos;

endmodule

@@ hdl/adc_reading_to_seven_segment_scan.sv @@
// adc_reading_to_seven_segment_scan: top level with input register, scan
// state, config registers and result register. Depends on a7s_pkg,
// a7s_scale and a7s_digit.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  s_data  (in_beat_t: action, sample)
//  m_       out  m_valid / m_ready  m_data  (out_beat_t: segments, digit_enable,
//                                            sample_taken)
//  cfg_     in   cfg_we             cfg_index, cfg_wdata
//
// One beat per cycle sustained while m_ready stays high; a beat is taken into the input
// register and its result is offered from the result register.
// The tick path (reciprocal multiply, subtract, segment lookup) sets the cycle length.
// Synchronous active-low reset clears valid flags, scan state and shown value, and loads the config reset values.
// A stalled m_ stage holds s_ready low only once the input register is full.

module adc_reading_to_seven_segment_scan import a7s_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_we,
    input  reg_index_t            cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_wdata
);

    logic                  in_valid_reg;
    in_beat_t              in_reg;
    logic                  out_valid_reg;
    out_beat_t             out_reg;
    out_beat_t             out_next;

    logic [COUNT_BITS-1:0] refresh_reg;
    logic [SCALE_BITS-1:0] scale_reg;
    logic [POS_BITS-1:0]   pos_reg, pos_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;

    logic [VALUE_BITS-1:0] scaled;
    logic [SEG_BITS-1:0]   tick_segments;
    logic [NUM_DIGITS-1:0] tick_enable;
    logic                  advance;
    logic                  take;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a7s_scale u_scale (
        .sample (in_reg.sample),
        .scale  (scale_reg),
        .value  (scaled)
    );

    a7s_digit u_digit (
        .value        (value_reg),
        .pos          (pos_reg),
        .segments     (tick_segments),
        .digit_enable (tick_enable)
    );

    assign take = (in_reg.action == ACT_SAMPLE) && (count_reg >= refresh_reg);

    always_comb begin
        out_next   = '0;
        pos_next   = pos_reg;
        count_next = count_reg;
        value_next = value_reg;
        if (in_reg.action == ACT_TICK) begin
            out_next.segments     = tick_segments;
            out_next.digit_enable = tick_enable;
            pos_next              = pos_reg + POS_BITS'(1);
            if (pos_reg == POS_BITS'(NUM_DIGITS - 1) && count_reg != COUNT_MAX) begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end else if (take) begin
            out_next.sample_taken = 1'b1;
            count_next            = '0;
            value_next            = scaled;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            refresh_reg   <= REFRESH_RESET;
            scale_reg     <= SCALE_RESET;
            pos_reg       <= '0;
            count_reg     <= '0;
            value_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                pos_reg       <= pos_next;
                count_reg     <= count_next;
                value_reg     <= value_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_REFRESH_SCANS: refresh_reg <= cfg_wdata[COUNT_BITS-1:0];
                    REG_SCALE:         scale_reg   <= cfg_wdata[SCALE_BITS-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        value_reg <= MAX_SHOWN)
        else $error("shown value above clamp limit");

    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.digit_enable == '0) ||
                     ($onehot(m_data.digit_enable) && !m_data.sample_taken)))
        else $error("result mixes tick and sample fields");

    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (in_reg.action == ACT_TICK) |=>
            pos_reg == $past(pos_reg) + POS_BITS'(1))
        else $error("scan position did not step on tick");

    a_pos_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && (in_reg.action == ACT_TICK)) |=> $stable(pos_reg))
        else $error("scan position moved without tick");

    a_taken_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && take |=> count_reg == '0)
        else $error("scan count not cleared after taken sample");

endmodule

@@ test/testbench.sv @@
// testbench: self-checking bench for adc_reading_to_seven_segment_scan, with a
// directed script, phased random traffic, random stalls and a built-in predictor.
// Depends on a7s_pkg and the block's RTL only.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import a7s_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_ITEMS   = 310;
    localparam int RANDOM_PHASES = 6;

    typedef enum logic [0:0] {
        ROW_BEAT  = 1'b0,
        ROW_WRITE = 1'b1
    } row_kind_t;

    typedef struct packed {
        row_kind_t        kind;
        action_t          action;
        reg_index_t       field_sel;
        logic [15:0]      value;     // sample for beats, register data for writes
        logic             typed;
        out_beat_t        want;
    } script_row_t;

    localparam out_beat_t NO_CHECK = '0;
    localparam out_beat_t IGNORED  = '0;
    localparam out_beat_t TAKEN    = {7'd0, 4'd0, 1'b1};

    localparam script_row_t SCRIPT [31] = '{
        // reset settings: blank digits show zero, early sample is dropped
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b1, {7'd63, 4'b0001, 1'b0}},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b1, {7'd63, 4'b0010, 1'b0}},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b1, {7'd63, 4'b0100, 1'b0}},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b1, {7'd63, 4'b1000, 1'b0}},
        '{ROW_BEAT,  ACT_SAMPLE, REG_SCALE,         16'd1023,  1'b1, IGNORED},
        // zero refresh with full scale: clamps to all nines
        '{ROW_WRITE, ACT_TICK,   REG_REFRESH_SCANS, 16'd0,     1'b0, NO_CHECK},
        '{ROW_WRITE, ACT_TICK,   REG_SCALE,         16'hFFFF,  1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_SAMPLE, REG_SCALE,         16'd1023,  1'b1, TAKEN},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b1, {7'd111, 4'b0001, 1'b0}},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b1, {7'd111, 4'b0010, 1'b0}},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b1, {7'd111, 4'b0100, 1'b0}},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b1, {7'd111, 4'b1000, 1'b0}},
        // most scans needed, zero scale
        '{ROW_WRITE, ACT_TICK,   REG_REFRESH_SCANS, 16'd15,    1'b0, NO_CHECK},
        '{ROW_WRITE, ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_SAMPLE, REG_SCALE,         16'd512,   1'b1, IGNORED},
        // unit scale shows the raw reading
        '{ROW_WRITE, ACT_TICK,   REG_REFRESH_SCANS, 16'd1,     1'b0, NO_CHECK},
        '{ROW_WRITE, ACT_TICK,   REG_SCALE,         16'd1024,  1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_SAMPLE, REG_SCALE,         16'd987,   1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_SAMPLE, REG_SCALE,         16'd5,     1'b0, NO_CHECK},
        // back to reset settings
        '{ROW_WRITE, ACT_TICK,   REG_SCALE,         16'd50000, 1'b0, NO_CHECK},
        '{ROW_WRITE, ACT_TICK,   REG_REFRESH_SCANS, 16'd9,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_SAMPLE, REG_SCALE,         16'd0,     1'b1, IGNORED},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK},
        '{ROW_BEAT,  ACT_TICK,   REG_SCALE,         16'd0,     1'b0, NO_CHECK}
    };

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_beat_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_beat_t           m_data;
    logic                cfg_we;
    reg_index_t          cfg_index;
    logic [CFG_BITS-1:0] cfg_wdata;

    // predictor state
    logic [1:0]            disp_pos;
    logic [3:0]            disp_digits [NUM_DIGITS];
    logic [COUNT_BITS-1:0] disp_count;
    logic [COUNT_BITS-1:0] cfg_refresh;
    logic [SCALE_BITS-1:0] cfg_scale;

    out_beat_t pending_display [$];

    int  mismatches      = 0;
    int  ticks_sent      = 0;
    int  samples_offered = 0;
    int  samples_taken   = 0;
    int  writes_done     = 0;
    bit  calm            = 1'b0;

    adc_reading_to_seven_segment_scan DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // advances the predicted display by one beat and returns its result
    function automatic out_beat_t next_display_beat(input in_beat_t beat);
        out_beat_t             r;
        logic [25:0]           product;
        logic [SCALE_BITS-1:0] shown;
        r = '0;
        if (beat.action == ACT_TICK) begin
            case (disp_digits[disp_pos])
                4'd0:    r.segments = 7'b0111111;
                4'd1:    r.segments = 7'b0000110;
                4'd2:    r.segments = 7'b1011011;
                4'd3:    r.segments = 7'b1001111;
                4'd4:    r.segments = 7'b1100110;
                4'd5:    r.segments = 7'b1101101;
                4'd6:    r.segments = 7'b1111101;
                4'd7:    r.segments = 7'b0000111;
                4'd8:    r.segments = 7'b1111111;
                4'd9:    r.segments = 7'b1101111;
                default: r.segments = 7'b0000000;
            endcase
            r.digit_enable = 4'b0001 << disp_pos;
            if (disp_pos == 2'd3 && disp_count != COUNT_MAX) begin
                disp_count = disp_count + 1'b1;
            end
            disp_pos = disp_pos + 1'b1;
        end else if (disp_count >= cfg_refresh) begin
            product = beat.sample * cfg_scale;
            shown   = product[25:SCALE_SHIFT];
            if (shown > 16'd9999) begin
                shown = 16'd9999;
            end
            disp_digits[0] = 4'(shown / 1000);
            disp_digits[1] = 4'((shown / 100) % 10);
            disp_digits[2] = 4'((shown / 10) % 10);
            disp_digits[3] = 4'(shown % 10);
            disp_count     = '0;
            r.sample_taken = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40) begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    task automatic send_beat(input in_beat_t beat, input logic typed, input out_beat_t want);
        out_beat_t predicted;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        predicted = next_display_beat(beat);
        pending_display.push_back(typed ? want : predicted);
        if (beat.action == ACT_TICK) ticks_sent++;
        else samples_offered++;
    endtask

    task automatic hold_off(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    task automatic drain(input int settle);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_display.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_BITS-1:0] value);
        drain(3);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_REFRESH_SCANS) cfg_refresh = value[COUNT_BITS-1:0];
        else cfg_scale = value;
        writes_done++;
    endtask

    // result checker
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_display.size() == 0) begin
                report_mismatch("unexpected beat, segments", m_data.segments, 0);
            end else begin
                want = pending_display.pop_front();
                if (m_data.segments != want.segments)
                    report_mismatch("segments", m_data.segments, want.segments);
                if (m_data.digit_enable != want.digit_enable)
                    report_mismatch("digit_enable", m_data.digit_enable, want.digit_enable);
                if (m_data.sample_taken != want.sample_taken)
                    report_mismatch("sample_taken", m_data.sample_taken, want.sample_taken);
                if (m_data.sample_taken) samples_taken++;
            end
        end
    end

    // receiver back-pressure in bursts
    initial begin
        m_ready = 1'b1;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                repeat ($urandom_range(1, 40)) @(negedge aclk);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("watchdog: %0d cycles without a beat", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        script_row_t           row;
        in_beat_t              beat;
        logic [COUNT_BITS-1:0] refresh;
        logic [SCALE_BITS-1:0] scale;
        bit                    gappy;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_REFRESH_SCANS;
        cfg_wdata = '0;

        disp_pos    = '0;
        disp_digits = '{default: 4'd0};
        disp_count  = '0;
        cfg_refresh = REFRESH_RESET;
        cfg_scale   = SCALE_RESET;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (SCRIPT[i]) begin
            row = SCRIPT[i];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.field_sel, row.value);
            end else begin
                beat.action = row.action;
                beat.sample = row.value[SAMPLE_BITS-1:0];
                send_beat(beat, row.typed, row.want);
            end
        end

        gappy = 1'b1;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin refresh = 4'd15; scale = 16'hFFFF; end
                1: begin refresh = 4'd1;  scale = 16'h0000; end
                2: begin refresh = 4'd0;  scale = 16'($urandom_range(0, 10240)); end
                5: begin refresh = 4'd4;  scale = SCALE_RESET; end
                default: begin
                    refresh = 4'($urandom_range(0, 15));
                    scale   = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 10240));
                end
            endcase
            write_reg(REG_REFRESH_SCANS, CFG_BITS'(refresh));
            write_reg(REG_SCALE, scale);
            calm = (phase == RANDOM_PHASES - 1);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 50 == 0) gappy = ($urandom_range(0, 3) != 0);
                // mostly offer samples only once enough scans have passed
                beat.action = ACT_TICK;
                if (disp_count >= cfg_refresh) begin
                    if ($urandom_range(0, 2) == 0) beat.action = ACT_SAMPLE;
                end else if ($urandom_range(0, 24) == 0) begin
                    beat.action = ACT_SAMPLE;
                end
                case ($urandom_range(0, 7))
                    0:       beat.sample = '0;
                    1:       beat.sample = '1;
                    default: beat.sample = SAMPLE_BITS'($urandom_range(0, 1023));
                endcase
                send_beat(beat, 1'b0, NO_CHECK);
                if (phase == 3 && n == PHASE_ITEMS / 2) begin
                    drain(0);
                end else if (!calm && gappy && $urandom_range(0, 7) == 0) begin
                    hold_off($urandom_range(1, 17));
                end
            end
        end

        drain(0);
        repeat (6) @(posedge aclk);
        $display("covered %0d scan ticks and %0d offered samples (%0d taken), %0d register writes",
                 ticks_sent, samples_offered, samples_taken, writes_done);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
